@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define CHECK_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next clock edge
`define CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pl0_pkg.sv @@
// package: token codes, error codes and word types of the token scanner
package pl0_pkg;

	localparam int unsigned TOK_W = 6;
	localparam int unsigned ERR_W = 3;

	localparam logic [TOK_W-1:0] TOK_NONE   = 6'd0;
	localparam logic [TOK_W-1:0] TOK_IDENT  = 6'd2;
	localparam logic [TOK_W-1:0] TOK_NUMBER = 6'd3;
	localparam logic [TOK_W-1:0] TOK_PLUS   = 6'd4;
	localparam logic [TOK_W-1:0] TOK_MINUS  = 6'd5;
	localparam logic [TOK_W-1:0] TOK_TIMES  = 6'd6;
	localparam logic [TOK_W-1:0] TOK_SLASH  = 6'd7;
	localparam logic [TOK_W-1:0] TOK_ODD    = 6'd8;
	localparam logic [TOK_W-1:0] TOK_EQL    = 6'd9;
	localparam logic [TOK_W-1:0] TOK_NEQ    = 6'd10;
	localparam logic [TOK_W-1:0] TOK_LSS    = 6'd11;
	localparam logic [TOK_W-1:0] TOK_LEQ    = 6'd12;
	localparam logic [TOK_W-1:0] TOK_GTR    = 6'd13;
	localparam logic [TOK_W-1:0] TOK_GEQ    = 6'd14;
	localparam logic [TOK_W-1:0] TOK_LPAREN = 6'd15;
	localparam logic [TOK_W-1:0] TOK_RPAREN = 6'd16;
	localparam logic [TOK_W-1:0] TOK_COMMA  = 6'd17;
	localparam logic [TOK_W-1:0] TOK_SEMI   = 6'd18;
	localparam logic [TOK_W-1:0] TOK_PERIOD = 6'd19;
	localparam logic [TOK_W-1:0] TOK_BECOMES = 6'd20;
	localparam logic [TOK_W-1:0] TOK_BEGIN  = 6'd21;
	localparam logic [TOK_W-1:0] TOK_END    = 6'd22;
	localparam logic [TOK_W-1:0] TOK_IF     = 6'd23;
	localparam logic [TOK_W-1:0] TOK_THEN   = 6'd24;
	localparam logic [TOK_W-1:0] TOK_WHILE  = 6'd25;
	localparam logic [TOK_W-1:0] TOK_DO     = 6'd26;
	localparam logic [TOK_W-1:0] TOK_CALL   = 6'd27;
	localparam logic [TOK_W-1:0] TOK_CONST  = 6'd28;
	localparam logic [TOK_W-1:0] TOK_VAR    = 6'd29;
	localparam logic [TOK_W-1:0] TOK_PROC   = 6'd30;
	localparam logic [TOK_W-1:0] TOK_WRITE  = 6'd31;
	localparam logic [TOK_W-1:0] TOK_READ   = 6'd32;
	localparam logic [TOK_W-1:0] TOK_ELSE   = 6'd33;

	localparam logic [ERR_W-1:0] ERR_NONE    = 3'd0;
	localparam logic [ERR_W-1:0] ERR_NAME    = 3'd1;
	localparam logic [ERR_W-1:0] ERR_NUMLEN  = 3'd2;
	localparam logic [ERR_W-1:0] ERR_BECOMES = 3'd3;
	localparam logic [ERR_W-1:0] ERR_CHAR    = 3'd4;

	// longest keyword, and number of keywords
	localparam int unsigned KW_MAX = 9;
	localparam int unsigned KW_NUM = 14;

	typedef logic [7:0] char_t;

	// one result word
	typedef struct packed {
		logic [TOK_W-1:0] token_code;
		char_t            lexeme_char;
		logic             lexeme_end;
		logic [ERR_W-1:0] error_code;
		logic             last_result;
	} tok_word_t;

	typedef struct packed {
		char_t ch;
		logic  end_of_text;
	} src_word_t;

	// keyword text, padded with zeros, first character in the top byte
	typedef logic [KW_MAX*8-1:0] kw_text_t;

	function automatic kw_text_t kw_text(input logic [3:0] idx);
		kw_text_t t;
		t = '0;
		case (idx)
			4'd0:  t = {"const", 32'h0};
			4'd1:  t = {"var", 48'h0};
			4'd2:  t = "procedure";
			4'd3:  t = {"call", 40'h0};
			4'd4:  t = {"begin", 32'h0};
			4'd5:  t = {"end", 48'h0};
			4'd6:  t = {"if", 56'h0};
			4'd7:  t = {"then", 40'h0};
			4'd8:  t = {"else", 40'h0};
			4'd9:  t = {"while", 32'h0};
			4'd10: t = {"do", 56'h0};
			4'd11: t = {"read", 40'h0};
			4'd12: t = {"write", 32'h0};
			4'd13: t = {"odd", 48'h0};
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic logic [3:0] kw_len(input logic [3:0] idx);
		logic [3:0] l;
		case (idx)
			4'd0, 4'd4, 4'd9, 4'd12:       l = 4'd5;
			4'd1, 4'd5, 4'd13:             l = 4'd3;
			4'd2:                          l = 4'd9;
			4'd3, 4'd7, 4'd8, 4'd11:       l = 4'd4;
			4'd6, 4'd10:                   l = 4'd2;
			default:                       l = 4'd0;
		endcase
		return l;
	endfunction

	function automatic logic [TOK_W-1:0] kw_code(input logic [3:0] idx);
		logic [TOK_W-1:0] c;
		case (idx)
			4'd0:  c = TOK_CONST;
			4'd1:  c = TOK_VAR;
			4'd2:  c = TOK_PROC;
			4'd3:  c = TOK_CALL;
			4'd4:  c = TOK_BEGIN;
			4'd5:  c = TOK_END;
			4'd6:  c = TOK_IF;
			4'd7:  c = TOK_THEN;
			4'd8:  c = TOK_ELSE;
			4'd9:  c = TOK_WHILE;
			4'd10: c = TOK_DO;
			4'd11: c = TOK_READ;
			4'd12: c = TOK_WRITE;
			4'd13: c = TOK_ODD;
			default: c = TOK_NONE;
		endcase
		return c;
	endfunction

	function automatic logic is_alpha(input char_t c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input char_t c);
		return c >= "0" && c <= "9";
	endfunction

endpackage

@@ rtl/pl0_stream_if.sv @@
// valid/ready channel interface carrying one payload word
interface pl0_stream_if #(
	parameter type word_t = logic [7:0]
) (
	input logic clk
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (input clk, output valid, input ready, output data);
	modport sink (input clk, input valid, output ready, input data);
endinterface

@@ rtl/pl0_kw_match.sv @@
// keyword matcher: steps through the keyword table one entry per cycle
module pl0_kw_match #(
	parameter int unsigned BUF_DEPTH = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [$clog2(BUF_DEPTH+1)-1:0] word_len,
	input  logic [BUF_DEPTH*8-1:0]        word_flat,
	output logic                          done,
	output logic                          hit,
	output logic [pl0_pkg::TOK_W-1:0]     code
);
	import pl0_pkg::*;

	localparam int unsigned LW = $clog2(BUF_DEPTH+1);
	localparam int unsigned CMP_N = (BUF_DEPTH < KW_MAX) ? BUF_DEPTH : KW_MAX;

	logic [3:0]  idx_q;
	logic        busy_q;
	logic        match;
	kw_text_t    txt;

	// compare current table entry with the buffered word
	always_comb begin
		txt = kw_text(idx_q);
		match = ({{(8-LW > 0 ? 8-LW : 0){1'b0}}, word_len} == 8'(kw_len(idx_q)));
		for (int i = 0; i < CMP_N; i++) begin
			if (i < int'(kw_len(idx_q)) &&
			    word_flat[i*8 +: 8] != txt[(KW_MAX-1-i)*8 +: 8])
				match = 1'b0;
		end
	end

	// table walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			done   <= 1'b0;
			hit    <= 1'b0;
			code   <= TOK_NONE;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				if (match || idx_q == 4'(KW_NUM-1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
					hit    <= match;
					code   <= kw_code(idx_q);
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end
		end
	end

	`include "assert_macros.svh"
	`CHECK_ALWAYS(a_idx_range, clk, arst_n, idx_q < 4'(KW_NUM), "keyword index out of range")
	`CHECK_NEXT(a_done_pulse, clk, arst_n, done, !done, "done held for two cycles")
	`CHECK_ALWAYS(a_hit_code, clk, arst_n, !(done && hit) || code != TOK_NONE, "hit without code")
endmodule

@@ rtl/pl0_token_scanner.sv @@
// top level: PL/0 token scanner, one source byte in, token words out
// a token's first word is loaded as its closing byte is taken after a lookahead byte or an
// error; from idle mode it goes through S_AFTER, a number through S_EMIT_WORD, and an
// identifier through S_KW (the 14-entry keyword table is walked one entry a cycle)
// throughput: 1 byte a cycle inside a word, a comment or after < > : / while the output is
// not stalled and no word is pending; a byte seen from idle mode is handled in S_AFTER first
// reset: asynchronous, idle mode, empty word, no error latched, output empty
module pl0_token_scanner #(
	parameter int unsigned MAX_IDENT_LEN     = 11,
	parameter int unsigned MAX_NUMBER_DIGITS = 5
) (
	input logic clk,
	input logic arst_n,
	pl0_stream_if.sink   src,
	pl0_stream_if.source tok
);
	import pl0_pkg::*;

	localparam int unsigned BUF_DEPTH = (MAX_IDENT_LEN > MAX_NUMBER_DIGITS) ?
		MAX_IDENT_LEN : MAX_NUMBER_DIGITS;
	localparam int unsigned LW = $clog2(BUF_DEPTH+1);
	localparam int unsigned IW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUMBER, M_LT, M_GT, M_COLON, M_SLASH, M_COMMENT, M_CSTAR
	} mode_t;

	typedef enum logic [2:0] {
		S_TAKE, S_KW, S_EMIT_WORD, S_AFTER, S_OUT1
	} seq_t;

	mode_t mode_q;
	seq_t  seq_q;
	char_t buf_q [BUF_DEPTH];
	logic [LW-1:0] len_q;
	logic [LW-1:0] pos_q;
	logic  err_q;
	logic  is_num_q;
	// pending work after a flushed word
	char_t ch_q;
	logic  eot_q;
	logic  tail_q;
	// output register
	logic  ov_q;
	tok_word_t ow_q;
	// single pending word following the current one
	logic  pv_q;
	tok_word_t pw_q;

	logic kw_done, kw_hit;
	logic [TOK_W-1:0] kw_code_w;
	logic [BUF_DEPTH*8-1:0] word_flat;

	// keyword walk start, registered when the word is closed
	logic kw_go;

	always_comb begin
		for (int i = 0; i < BUF_DEPTH; i++) word_flat[i*8 +: 8] = buf_q[i];
	end

	pl0_kw_match #(.BUF_DEPTH(BUF_DEPTH)) u_kw (
		.clk(clk), .arst_n(arst_n), .start(kw_go), .word_len(len_q),
		.word_flat(word_flat), .done(kw_done), .hit(kw_hit), .code(kw_code_w)
	);

	logic out_free;
	assign out_free = !ov_q || tok.ready;
	assign tok.valid = ov_q;
	assign tok.data  = ow_q;
	assign src.ready = (seq_q == S_TAKE) && out_free && !pv_q;

	function automatic tok_word_t mk(input logic [TOK_W-1:0] t, input char_t c,
		input logic e, input logic [ERR_W-1:0] er, input logic l);
		tok_word_t w;
		w.token_code = t; w.lexeme_char = c; w.lexeme_end = e;
		w.error_code = er; w.last_result = l;
		return w;
	endfunction

	// decision on one byte in a non-word context (idle view)
	typedef struct packed {
		logic      emit;
		tok_word_t w;
		mode_t     nm;
		logic      start_word;
		logic      err;
	} idle_res_t;

	function automatic idle_res_t idle_byte(input char_t c);
		idle_res_t r;
		r.emit = 1'b1; r.nm = M_IDLE; r.start_word = 1'b0; r.err = 1'b0;
		r.w = mk(TOK_NONE, 8'd0, 1'b1, ERR_NONE, 1'b1);
		if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
			r.emit = 1'b0;
		end else if (is_alpha(c) || is_digit(c)) begin
			r.emit = 1'b0; r.start_word = 1'b1;
			r.nm = is_alpha(c) ? M_IDENT : M_NUMBER;
		end else begin
			case (c)
				"+": r.w.token_code = TOK_PLUS;
				"-": r.w.token_code = TOK_MINUS;
				"*": r.w.token_code = TOK_TIMES;
				"(": r.w.token_code = TOK_LPAREN;
				")": r.w.token_code = TOK_RPAREN;
				"=": r.w.token_code = TOK_EQL;
				",": r.w.token_code = TOK_COMMA;
				".": r.w.token_code = TOK_PERIOD;
				";": r.w.token_code = TOK_SEMI;
				"<": begin r.emit = 1'b0; r.nm = M_LT; end
				">": begin r.emit = 1'b0; r.nm = M_GT; end
				":": begin r.emit = 1'b0; r.nm = M_COLON; end
				"/": begin r.emit = 1'b0; r.nm = M_SLASH; end
				default: begin r.w.error_code = ERR_CHAR; r.err = 1'b1; end
			endcase
		end
		return r;
	endfunction

	// idle view of the stored byte and of the byte on the input
	idle_res_t ir;
	assign ir = idle_byte(eot_q ? 8'd0 : ch_q);
	idle_res_t ir_in;
	assign ir_in = idle_byte(src.data.ch);

	logic src_acc;
	assign src_acc = src.valid && src.ready;

	logic [IW-1:0] pos_idx;
	assign pos_idx = pos_q[IW-1:0];

	// main sequencer with registered output and one pending word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; seq_q <= S_TAKE; len_q <= '0; pos_q <= '0;
			err_q <= 1'b0; is_num_q <= 1'b0; ch_q <= '0; eot_q <= 1'b0;
			tail_q <= 1'b0; ov_q <= 1'b0; pv_q <= 1'b0; kw_go <= 1'b0;
			ow_q <= '0; pw_q <= '0;
		end else begin
			kw_go <= 1'b0;
			if (ov_q && tok.ready) begin
				ov_q <= pv_q; ow_q <= pw_q; pv_q <= 1'b0;
			end
			unique case (seq_q)
				S_TAKE: begin
					if (src_acc) begin
						ch_q <= src.data.ch; eot_q <= src.data.end_of_text;
						if (src.data.end_of_text) begin
							if (err_q) begin
								err_q <= 1'b0; mode_q <= M_IDLE; len_q <= '0;
							end else begin
								unique case (mode_q)
									M_IDENT, M_NUMBER: begin
										is_num_q <= (mode_q == M_NUMBER);
										seq_q <= (mode_q == M_NUMBER) ? S_EMIT_WORD : S_KW;
										kw_go <= (mode_q == M_IDENT);
										pos_q <= '0; tail_q <= 1'b0;
									end
									M_LT: begin ov_q <= 1'b1;
										ow_q <= mk(TOK_LSS, 8'd0, 1'b1, ERR_NONE, 1'b1); end
									M_GT: begin ov_q <= 1'b1;
										ow_q <= mk(TOK_GTR, 8'd0, 1'b1, ERR_NONE, 1'b1); end
									M_SLASH: begin ov_q <= 1'b1;
										ow_q <= mk(TOK_SLASH, 8'd0, 1'b1, ERR_NONE, 1'b1); end
									M_COLON: begin ov_q <= 1'b1;
										ow_q <= mk(TOK_NONE, 8'd0, 1'b1, ERR_BECOMES, 1'b1); end
									default: ;
								endcase
								if (mode_q != M_IDENT && mode_q != M_NUMBER) begin
									mode_q <= M_IDLE; len_q <= '0;
								end
							end
						end else if (!err_q) begin
							unique case (mode_q)
								M_IDENT: begin
									if (is_alpha(src.data.ch) || is_digit(src.data.ch)) begin
										if (len_q >= LW'(MAX_IDENT_LEN)) begin
											ov_q <= 1'b1; err_q <= 1'b1; mode_q <= M_IDLE;
											len_q <= '0;
											ow_q <= mk(TOK_NONE, 8'd0, 1'b1, ERR_NAME, 1'b1);
										end else begin
											buf_q[len_q[IW-1:0]] <= src.data.ch;
											len_q <= len_q + 1'b1;
										end
									end else begin
										is_num_q <= 1'b0; seq_q <= S_KW; kw_go <= 1'b1;
										pos_q <= '0; tail_q <= 1'b1;
									end
								end
								M_NUMBER: begin
									if (is_digit(src.data.ch)) begin
										if (len_q >= LW'(MAX_NUMBER_DIGITS)) begin
											ov_q <= 1'b1; err_q <= 1'b1; mode_q <= M_IDLE;
											len_q <= '0;
											ow_q <= mk(TOK_NONE, 8'd0, 1'b1, ERR_NUMLEN, 1'b1);
										end else begin
											buf_q[len_q[IW-1:0]] <= src.data.ch;
											len_q <= len_q + 1'b1;
										end
									end else if (is_alpha(src.data.ch)) begin
										ov_q <= 1'b1; err_q <= 1'b1; mode_q <= M_IDLE;
										len_q <= '0;
										ow_q <= mk(TOK_NONE, 8'd0, 1'b1, ERR_NAME, 1'b1);
									end else begin
										is_num_q <= 1'b1; seq_q <= S_EMIT_WORD;
										pos_q <= '0; tail_q <= 1'b1;
									end
								end
								M_LT: begin
									if (src.data.ch == ">" || src.data.ch == "=") begin
										ov_q <= 1'b1; mode_q <= M_IDLE;
										ow_q <= mk((src.data.ch == ">") ? TOK_NEQ : TOK_LEQ,
											8'd0, 1'b1, ERR_NONE, 1'b1);
									end else begin
										ov_q <= 1'b1; mode_q <= M_IDLE; seq_q <= S_AFTER;
										ow_q <= mk(TOK_LSS, 8'd0, 1'b1, ERR_NONE, !ir_in.emit);
									end
								end
								M_GT: begin
									ov_q <= 1'b1; mode_q <= M_IDLE;
									if (src.data.ch == "=")
										ow_q <= mk(TOK_GEQ, 8'd0, 1'b1, ERR_NONE, 1'b1);
									else begin
										seq_q <= S_AFTER;
										ow_q <= mk(TOK_GTR, 8'd0, 1'b1, ERR_NONE, !ir_in.emit);
									end
								end
								M_COLON: begin
									ov_q <= 1'b1; mode_q <= M_IDLE;
									if (src.data.ch == "=")
										ow_q <= mk(TOK_BECOMES, 8'd0, 1'b1, ERR_NONE, 1'b1);
									else begin
										err_q <= 1'b1;
										ow_q <= mk(TOK_NONE, 8'd0, 1'b1, ERR_BECOMES, 1'b1);
									end
								end
								M_SLASH: begin
									if (src.data.ch == "*") mode_q <= M_COMMENT;
									else begin
										ov_q <= 1'b1; mode_q <= M_IDLE; seq_q <= S_AFTER;
										ow_q <= mk(TOK_SLASH, 8'd0, 1'b1, ERR_NONE,
											!ir_in.emit);
									end
								end
								M_COMMENT: begin
									if (src.data.ch == "*") mode_q <= M_CSTAR;
								end
								M_CSTAR: begin
									if (src.data.ch == "/") mode_q <= M_IDLE;
									else if (src.data.ch != "*") mode_q <= M_COMMENT;
								end
								default: seq_q <= S_AFTER;
							endcase
						end
					end
				end
				S_KW: begin
					if (kw_done) begin
						if (kw_hit) begin
							if (out_free) begin
								ov_q <= 1'b1;
								ow_q <= mk(kw_code_w, 8'd0, 1'b1, ERR_NONE,
									!tail_q || !ir.emit);
								len_q <= '0;
								seq_q <= tail_q ? S_AFTER : S_TAKE;
								if (!tail_q) mode_q <= M_IDLE;
							end else begin
								pv_q <= 1'b1;
								pw_q <= mk(kw_code_w, 8'd0, 1'b1, ERR_NONE,
									!tail_q || !ir.emit);
								len_q <= '0;
								seq_q <= tail_q ? S_AFTER : S_OUT1;
								if (!tail_q) mode_q <= M_IDLE;
							end
						end else begin
							seq_q <= S_EMIT_WORD;
						end
					end
				end
				S_EMIT_WORD: begin
					if (out_free && !(ov_q && tok.ready && pv_q)) begin
						ov_q <= 1'b1;
						ow_q <= mk(is_num_q ? TOK_NUMBER : TOK_IDENT, buf_q[pos_idx],
							pos_q + 1'b1 == len_q, ERR_NONE,
							(pos_q + 1'b1 == len_q) && (!tail_q || !ir.emit));
						pos_q <= pos_q + 1'b1;
						if (pos_q + 1'b1 == len_q) begin
							len_q <= '0;
							if (tail_q) seq_q <= S_AFTER;
							else begin seq_q <= S_TAKE; mode_q <= M_IDLE; end
						end
					end
				end
				S_AFTER: begin
					// stored byte now seen from idle, after a flushed token or a byte taken in idle mode
					if (!ir.emit || (!pv_q && out_free)) begin
						mode_q <= ir.nm;
						seq_q <= S_TAKE;
						if (ir.start_word) begin
							buf_q[0] <= ch_q; len_q <= LW'(1);
						end
						if (ir.err) begin
							err_q <= 1'b1; len_q <= '0;
						end
						if (ir.emit) begin
							ov_q <= 1'b1; ow_q <= ir.w;
						end
					end
				end
				S_OUT1: begin
					if (!pv_q) seq_q <= S_TAKE;
				end
				default: seq_q <= S_TAKE;
			endcase
		end
	end

	`include "assert_macros.svh"
	`CHECK_ALWAYS(a_len_cap, clk, arst_n, len_q <= LW'(BUF_DEPTH), "word length past buffer")
	`CHECK_ALWAYS(a_no_take_busy, clk, arst_n, !src.ready || seq_q == S_TAKE,
		"input taken while sequencer busy")
	`CHECK_ALWAYS(a_pend_needs_out, clk, arst_n, !pv_q || ov_q, "pending word without output")
endmodule
